### hw/rtl/audio_requantize_dither_assert.svh
// Assertion macros shared by the requantize dither checker.
`ifndef AUDIO_REQUANTIZE_DITHER_ASSERT_SVH
`define AUDIO_REQUANTIZE_DITHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define ARQD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define ARQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ard_pkg.sv
// Types and constants for the audio requantize dither block.
`default_nettype none

package ard_pkg;

   localparam int WORD_W        = 32;
   localparam int HEADROOM_BITS = 4;
   localparam int MAX_CHANNELS  = 4;
   localparam int POS_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RND_W         = 20;
   localparam int TBITS_W       = 6;
   localparam int CCOUNT_W      = 3;
   localparam int REQ_DATA_W    = ((WORD_W + RND_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [WORD_W-1:0] GEN_XOR = 32'h1020_4080;
   localparam logic [WORD_W-1:0] GEN_ADD = 32'h7864_9E7D;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_DEFAULT = 2'd1,
      MODE_NOISE   = 2'd2,
      MODE_SIMPLE  = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_TARGET_BITS = 3'd1,
      CSR_CHANNELS    = 3'd2,
      CSR_SEED_A      = 3'd3,
      CSR_SEED_B      = 3'd4
   } csr_index_type;

   typedef struct packed {
      mode_type                 mode;
      logic [TBITS_W-1:0]       target_bits;
      logic [CCOUNT_W-1:0]      channel_count;
      logic [WORD_W-1:0]        seed_a;
      logic [WORD_W-1:0]        seed_b;
   } ard_cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0]                    gen_a;
      logic [WORD_W-1:0]                    gen_b;
      logic [MAX_CHANNELS-1:0][WORD_W-1:0]  err;
      logic [POS_W-1:0]                     pos;
   } ard_state_type;

endpackage

`default_nettype wire

### hw/rtl/audio_requantize_dither.sv
// Top level of the audio requantize dither block: registers, handshake and state.
//
// Usage: mix samples enter on the req_ stream, one request per sample, and
// dithered samples leave on the rsp_ stream in the same order, one per request.
// req_tdata carries the 32-bit sample and 20 noise bits; req_tuser set clears the
// per-channel shaping errors and the channel position and reloads the generator
// from the seeds before that request is processed. The csr_ port writes mode,
// target bits, channel count and the two generator seeds; write it only while
// the stream is idle. An accepted request is held in the request register; its
// result then moves to the result register, which drives rsp_tvalid and rsp_tdata.
// Throughput: one request per cycle unless stalled; work between the registers
// is combinational; state updates as each request moves to the result register.
// Reset (synchronous): both registers empty, generator words, errors and
// channel position zero, mode default, 16 target bits, 2 channels, seeds zero.
// When the receiver stalls the result holds; one more request is still taken
// into the request register, then req_tready drops until the result is taken.
`default_nettype none

module audio_requantize_dither (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ard_pkg::REQ_DATA_W-1:0]    req_tdata,  // sample_in[31:0], random_bits[51:32], zero pad
   input  logic                              req_tuser,  // clear_state
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ard_pkg::WORD_W-1:0]        rsp_tdata,  // sample_out[31:0]
   input  logic                              csr_we,
   input  logic [ard_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ard_pkg::WORD_W-1:0]        csr_wdata
);
   import ard_pkg::*;

   ard_cfg_type          cfg_ff;
   ard_cfg_type          cfg_in;
   ard_state_type        state_ff;
   ard_state_type        state_in;
   ard_state_type        state_calc;
   logic                 req_valid_ff;
   logic                 req_valid_in;
   logic [WORD_W-1:0]    sample_ff;
   logic [RND_W-1:0]     rnd_ff;
   logic                 clear_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [WORD_W-1:0]    rsp_data_ff;
   logic [WORD_W-1:0]    rsp_data_in;
   logic [WORD_W-1:0]    sample_calc;
   logic                 advance;
   logic                 req_take;

   ard_calc u_calc (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .sample     (sample_ff),
      .rnd        (rnd_ff),
      .clear      (clear_ff),
      .sample_out (sample_calc),
      .state_nxt  (state_calc)
   );

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:        cfg_in.mode          = mode_type'(csr_wdata[1:0]);
            CSR_TARGET_BITS: cfg_in.target_bits   = csr_wdata[TBITS_W-1:0];
            CSR_CHANNELS:    cfg_in.channel_count = csr_wdata[CCOUNT_W-1:0];
            CSR_SEED_A:      cfg_in.seed_a        = csr_wdata;
            CSR_SEED_B:      cfg_in.seed_b        = csr_wdata;
            default:         cfg_in               = cfg_ff;
         endcase
      end

      priority if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      state_in    = advance ? state_calc : state_ff;
      rsp_data_in = advance ? sample_calc : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_DEFAULT;
         cfg_ff.target_bits   <= TBITS_W'(16);
         cfg_ff.channel_count <= CCOUNT_W'(2);
         cfg_ff.seed_a        <= '0;
         cfg_ff.seed_b        <= '0;
         state_ff             <= '0;
         req_valid_ff         <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_tdata[WORD_W-1:0];
         rnd_ff    <= req_tdata[WORD_W+RND_W-1:WORD_W];
         clear_ff  <= req_tuser;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### hw/rtl/ard_calc.sv
// Single-pass dither datapath: noise generator, shaped rounding, channel step.
`default_nettype none

module ard_calc (
   input  ard_pkg::ard_cfg_type            cfg,
   input  ard_pkg::ard_state_type          state_cur,
   input  logic [ard_pkg::WORD_W-1:0]      sample,
   input  logic [ard_pkg::RND_W-1:0]       rnd,
   input  logic                            clear,
   output logic [ard_pkg::WORD_W-1:0]      sample_out,
   output ard_pkg::ard_state_type          state_nxt
);
   import ard_pkg::*;

   ard_state_type        st;
   logic [TBITS_W:0]     noise_shift;
   logic                 noise_on;
   logic [WORD_W-1:0]    ga_rot;
   logic [WORD_W-1:0]    ga_new;
   logic [WORD_W-1:0]    ga_swap;
   logic [WORD_W-1:0]    gb_new;
   logic [WORD_W-1:0]    noise_sample;
   logic                 tb_ok;
   logic                 cc_ok;
   logic [TBITS_W-1:0]   rshift;
   logic                 rs_ok;
   logic                 simple_on;
   logic [WORD_W-1:0]    low_mask;
   logic [WORD_W-1:0]    err_cur;
   logic [WORD_W-1:0]    val;
   logic [WORD_W-1:0]    rounded;
   logic [CCOUNT_W:0]    pos_inc;

   always_comb begin
      // Apply a clear before the item is processed.
      st = state_cur;
      if (clear) begin
         st.gen_a = cfg.seed_a;
         st.gen_b = cfg.seed_b;
         st.err   = '0;
         st.pos   = '0;
      end

      // Noise generator step.
      noise_shift  = {1'b0, cfg.target_bits} + (TBITS_W+1)'(HEADROOM_BITS + 1);
      noise_on     = (noise_shift < (TBITS_W+1)'(WORD_W));
      ga_rot       = {st.gen_a[WORD_W-2:0], st.gen_a[WORD_W-1]} ^ GEN_XOR;
      ga_new       = ga_rot + GEN_ADD + {st.gen_b[WORD_W-3:0], 2'b00};
      ga_swap      = {ga_new[WORD_W/2-1:0], ga_new[WORD_W-1:WORD_W/2]};
      gb_new       = st.gen_b + ga_swap + {ga_swap[WORD_W-3:0], 2'b00};
      noise_sample = sample + WORD_W'($signed(gb_new) >>> noise_shift[4:0]);

      // Shaped rounding: noise minus bias plus half step reduces to the masked noise.
      tb_ok     = (cfg.target_bits == TBITS_W'(8)) || (cfg.target_bits == TBITS_W'(16)) ||
                  (cfg.target_bits == TBITS_W'(24));
      cc_ok     = (cfg.channel_count == CCOUNT_W'(1)) || (cfg.channel_count == CCOUNT_W'(2)) ||
                  (cfg.channel_count == CCOUNT_W'(4));
      rshift    = TBITS_W'(WORD_W - HEADROOM_BITS) - cfg.target_bits;
      rs_ok     = (rshift != '0) && (rshift < TBITS_W'(WORD_W)) && !rshift[TBITS_W-1];
      simple_on = tb_ok && cc_ok && rs_ok;
      low_mask  = (WORD_W'(1) << rshift[4:0]) - WORD_W'(1);
      err_cur   = st.err[st.pos];
      val       = sample + {err_cur[WORD_W-1], err_cur[WORD_W-1:1]};
      rounded   = (val + ({{(WORD_W-RND_W){1'b0}}, rnd} & low_mask)) & ~low_mask;

      state_nxt  = st;
      sample_out = sample;
      unique case (cfg.mode)
         MODE_NONE: begin
            sample_out = sample;
         end
         MODE_SIMPLE: begin
            if (simple_on) begin
               sample_out            = rounded;
               state_nxt.err[st.pos] = val - rounded;
            end
         end
         MODE_DEFAULT, MODE_NOISE: begin
            if (noise_on) begin
               sample_out      = noise_sample;
               state_nxt.gen_a = ga_new;
               state_nxt.gen_b = gb_new;
            end
         end
         default: begin
            sample_out = sample;
         end
      endcase

      // Advance the channel position, wrapping at the channel count or MAX_CHANNELS.
      pos_inc = {{(CCOUNT_W+1-POS_W){1'b0}}, st.pos} + (CCOUNT_W+1)'(1);
      if ((pos_inc >= {1'b0, cfg.channel_count}) ||
          (pos_inc >= (CCOUNT_W+1)'(MAX_CHANNELS))) begin
         state_nxt.pos = '0;
      end else begin
         state_nxt.pos = pos_inc[POS_W-1:0];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ard_checker.sv
// Port-level checker for the audio requantize dither block, bound to the top level.
`default_nettype none
`include "audio_requantize_dither_assert.svh"

module ard_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ard_pkg::WORD_W-1:0]        rsp_tdata   // sample_out[31:0]
);

   // No result may be pending right after reset.
   `ARQD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // A stalled result holds its value.
   `ARQD_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // An empty and ready result side never blocks requests.
   `ARQD_ASSERT_IMPLY(a_no_block, clock, reset, !rsp_tvalid && rsp_tready, req_tready, "request blocked while output side empty")

   // A request accepted out of reset is followed by a valid result on rsp_tvalid.
   `ARQD_ASSERT_IMPLY(a_latency, clock, reset, $past(req_tvalid && req_tready, 2) && !$past(reset, 2) && !$past(reset), rsp_tvalid, "result missing two cycles after request")

endmodule

bind audio_requantize_dither ard_checker u_ard_checker (.*);

`default_nettype wire
